// ----- hdl/ltm_pkg.sv -----
// Shared types, codes and reset values for the link throughput monitor.
package ltm_pkg;

  // Input operation codes.
  typedef enum logic [2:0] {
    OP_RX_PKT  = 3'd0,
    OP_TX_PKT  = 3'd1,
    OP_RX_BYTE = 3'd2,
    OP_TX_BYTE = 3'd3,
    OP_TICK    = 3'd4
  } ltm_op_t;

  // Result outcome codes.
  typedef enum logic [1:0] {
    OUT_SHORT    = 2'd0,
    OUT_STALE    = 2'd1,
    OUT_MEASURED = 2'd2
  } ltm_outcome_t;

  // CPU mode request codes.
  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_BUSY = 2'd1,
    MODE_IDLE = 2'd2
  } ltm_mode_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_PERIOD    = 3'd0,
    REG_WINDOW    = 3'd1,
    REG_LOAD_LOW  = 3'd2,
    REG_BIND      = 3'd3,
    REG_TX_HIGH   = 3'd4,
    REG_TX_LOW    = 3'd5,
    REG_RX_HIGH   = 3'd6,
    REG_RX_LOW    = 3'd7
  } ltm_reg_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_FIN  = 2'd2
  } ltm_state_t;

  typedef struct packed {
    logic [15:0] period;
    logic [7:0]  window;
    logic [15:0] load_low;
    logic        bind_en;
    logic [15:0] tx_high;
    logic [15:0] tx_low;
    logic [15:0] rx_high;
    logic [15:0] rx_low;
  } ltm_cfg_t;

  // Classification of one tick, passed from the front to the back.
  typedef struct packed {
    ltm_outcome_t outcome;
    logic         closed;
    logic [31:0]  dur;
  } ltm_tick_t;

  localparam ltm_cfg_t CFG_RESET = '{
    period:   16'd100,
    window:   8'd20,
    load_low: 16'd50,
    bind_en:  1'b1,
    tx_high:  16'd200,
    tx_low:   16'd150,
    rx_high:  16'd200,
    rx_low:   16'd150
  };

  // Stale limit for the reset configuration: period * window * 4.
  localparam logic [31:0] STALE_LIM_RESET = 32'd8000;

  localparam int QUEUE_DEPTH = 2;

  localparam int DATA_BITS = 32;

endpackage

// ----- hdl/ltm_div.sv -----
// One lane of the restoring divider, one quotient bit per cycle while step is high.
module ltm_div import ltm_pkg::*; #(
  parameter int DW = 42
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic                 step,
  input  logic [DW-1:0]        dividend,
  input  logic [DATA_BITS-1:0] divisor,
  output logic [DW-1:0]        quotient
);

  logic [DATA_BITS-1:0] rem;
  logic [DW-1:0]        acc;
  logic [DATA_BITS:0]   rem_sh;
  logic                 ge;
  logic [DATA_BITS:0]   diff;

  // The dividend shifts out of the top of acc while quotient bits shift in.
  always_comb begin
    rem_sh = {rem, acc[DW-1]};
    ge     = rem_sh >= {1'b0, divisor};
    diff   = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      acc <= dividend;
    end else if (step) begin
      rem <= ge ? diff[DATA_BITS-1:0] : rem_sh[DATA_BITS-1:0];
      acc <= {acc[DW-2:0], ge};
    end
  end

  assign quotient = acc;

endmodule

// ----- hdl/ltm_queue.sv -----
// Short register queue between the front and the back.
module ltm_queue import ltm_pkg::*; #(
  parameter int W = 195
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign full       = count == NW'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hdl/ltm_front.sv -----
// Front end: takes beats, keeps the counters and classifies each tick.
module ltm_front import ltm_pkg::*; #(
  parameter int COUNTER_BITS = 32
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  ltm_cfg_t                                    cfg,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic [2:0]                                  opcode,
  input  logic [15:0]                                 amount,
  input  logic [31:0]                                 now_ms,
  input  logic                                        q_full,
  output logic                                        q_push,
  output logic [$bits(ltm_tick_t)+5*COUNTER_BITS-1:0] q_data
);

  localparam int CB = COUNTER_BITS;

  logic [CB-1:0] rx_pkt;
  logic [CB-1:0] tx_pkt;
  logic [CB-1:0] rx_byte;
  logic [CB-1:0] tx_byte;
  logic [7:0]    tick_count;
  logic [31:0]   window_start;
  logic [31:0]   stale_lim;
  logic [23:0]   lim_prod;

  logic          accept;
  logic [7:0]    tick_next;
  logic [31:0]   dur;
  logic          is_short;
  logic          is_stale;
  logic          restart;
  ltm_tick_t     info;
  logic [CB-1:0] total;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    lim_prod  = cfg.period * cfg.window;
    stale_lim = {6'd0, lim_prod, 2'd0};
    tick_next = tick_count + 8'd1;
    dur       = now_ms - window_start;
    is_short  = (dur == '0) || (dur < 32'(cfg.period >> 1));
    is_stale  = !is_short && (dur > stale_lim);
    total     = rx_pkt + tx_pkt;
    info.dur  = dur;
    if (is_short) begin
      info.outcome = OUT_SHORT;
    end else if (is_stale) begin
      info.outcome = OUT_STALE;
    end else begin
      info.outcome = OUT_MEASURED;
    end
    info.closed = !is_short && !is_stale && (tick_next >= cfg.window);
    restart     = is_stale || info.closed;
    q_push      = accept && (ltm_op_t'(opcode) == OP_TICK);
  end

  assign q_data = {info, total, tx_pkt, rx_pkt, rx_byte, tx_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_pkt       <= '0;
      tx_pkt       <= '0;
      rx_byte      <= '0;
      tx_byte      <= '0;
      tick_count   <= '0;
      window_start <= '0;
    end else begin
      if (accept) begin
        case (ltm_op_t'(opcode))
          OP_RX_PKT:  rx_pkt  <= rx_pkt + CB'(amount);
          OP_TX_PKT:  tx_pkt  <= tx_pkt + CB'(amount);
          OP_RX_BYTE: rx_byte <= rx_byte + CB'(amount);
          OP_TX_BYTE: tx_byte <= tx_byte + CB'(amount);
          OP_TICK: begin
            if (restart) begin
              rx_pkt       <= '0;
              tx_pkt       <= '0;
              rx_byte      <= '0;
              tx_byte      <= '0;
              tick_count   <= '0;
              window_start <= now_ms;
            end else begin
              tick_count <= tick_next;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- hdl/ltm_back.sv -----
// Back end: divides the tick snapshot into rates and applies the mode hysteresis.
module ltm_back import ltm_pkg::*; #(
  parameter int COUNTER_BITS = 32
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  ltm_cfg_t                                    cfg,
  input  logic                                        q_valid,
  input  logic [$bits(ltm_tick_t)+5*COUNTER_BITS-1:0] q_data,
  output logic                                        q_pop,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic [1:0]                                  outcome,
  output logic [31:0]                                 total_pps,
  output logic [31:0]                                 tx_pps,
  output logic [31:0]                                 rx_pps,
  output logic [31:0]                                 rx_rate_mbps,
  output logic [31:0]                                 tx_rate_mbps,
  output logic                                        rx_busy,
  output logic [1:0]                                  cpu_mode,
  output logic                                        cpu_mode_changed,
  output logic                                        window_closed
);

  localparam int CB = COUNTER_BITS;
  localparam int DW = (CB + 10 > DATA_BITS) ? CB + 10 : DATA_BITS + 1;
  localparam int CW = $clog2(DW);

  ltm_state_t state, state_next;
  logic [CW-1:0]        cnt;
  ltm_tick_t            info;
  logic [DATA_BITS-1:0] dur;
  logic                 busy_flag;
  ltm_mode_t            mode;

  ltm_tick_t     head_info;
  logic [CB-1:0] h_total, h_tx_pkt, h_rx_pkt, h_rx_byte, h_tx_byte;
  logic [DW-1:0] dvd_tot, dvd_tx, dvd_rx, dvd_rxb, dvd_txb;
  logic [DW-1:0] quo_tot, quo_tx, quo_rx, quo_rxb, quo_txb;

  logic          div_step;
  logic          out_write;
  logic          measured;
  logic          busy_new;
  ltm_mode_t     req;
  logic          changed;

  assign h_tx_byte = q_data[CB-1:0];
  assign h_rx_byte = q_data[2*CB-1:CB];
  assign h_rx_pkt  = q_data[3*CB-1:2*CB];
  assign h_tx_pkt  = q_data[4*CB-1:3*CB];
  assign h_total   = q_data[5*CB-1:4*CB];
  assign head_info = q_data[$bits(ltm_tick_t)+5*CB-1:5*CB];

  // Times 1000 as 1024 - 32 + 8, kept exact in the wider dividend.
  assign dvd_tot = DW'({h_total, 10'd0}) - DW'({h_total, 5'd0}) + DW'({h_total, 3'd0});
  assign dvd_tx  = DW'({h_tx_pkt, 10'd0}) - DW'({h_tx_pkt, 5'd0}) + DW'({h_tx_pkt, 3'd0});
  assign dvd_rx  = DW'({h_rx_pkt, 10'd0}) - DW'({h_rx_pkt, 5'd0}) + DW'({h_rx_pkt, 3'd0});
  assign dvd_rxb = DW'(h_rx_byte >> 7);
  assign dvd_txb = DW'(h_tx_byte >> 7);

  ltm_div #(.DW(DW)) u_div_tot (
    .clk(clk), .load(q_pop), .step(div_step),
    .dividend(dvd_tot), .divisor(dur), .quotient(quo_tot)
  );
  ltm_div #(.DW(DW)) u_div_tx (
    .clk(clk), .load(q_pop), .step(div_step),
    .dividend(dvd_tx), .divisor(dur), .quotient(quo_tx)
  );
  ltm_div #(.DW(DW)) u_div_rx (
    .clk(clk), .load(q_pop), .step(div_step),
    .dividend(dvd_rx), .divisor(dur), .quotient(quo_rx)
  );
  ltm_div #(.DW(DW)) u_div_rxb (
    .clk(clk), .load(q_pop), .step(div_step),
    .dividend(dvd_rxb), .divisor(dur), .quotient(quo_rxb)
  );
  ltm_div #(.DW(DW)) u_div_txb (
    .clk(clk), .load(q_pop), .step(div_step),
    .dividend(dvd_txb), .divisor(dur), .quotient(quo_txb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_step   = 1'b0;
    out_write  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = (head_info.outcome == OUT_MEASURED) ? ST_DIV : ST_FIN;
        end
      end
      ST_DIV: begin
        div_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid || !out_stall) begin
          out_write  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Thresholds are compared against the exact quotients, not the saturated ones.
  always_comb begin
    measured = info.outcome == OUT_MEASURED;
    busy_new = quo_rxb > DW'(cfg.load_low);
    if ((quo_txb > DW'(cfg.tx_high)) || (quo_rxb > DW'(cfg.rx_high))) begin
      req = MODE_BUSY;
    end else if ((quo_txb < DW'(cfg.tx_low)) && (quo_rxb < DW'(cfg.rx_low))) begin
      req = MODE_IDLE;
    end else begin
      req = MODE_NONE;
    end
    changed = measured && cfg.bind_en && (req != MODE_NONE) && (req != mode);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy_flag <= 1'b0;
      mode      <= MODE_NONE;
    end else begin
      if (out_write) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (out_write && measured) begin
        busy_flag <= busy_new;
      end
      if (out_write && changed) begin
        mode <= req;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      info <= head_info;
      dur  <= head_info.dur;
      cnt  <= CW'(DW - 1);
    end else if (div_step) begin
      cnt <= cnt - 1'b1;
    end
    if (out_write) begin
      outcome          <= info.outcome;
      total_pps        <= !measured ? '0 : (|quo_tot[DW-1:DATA_BITS]) ? '1
                                           : quo_tot[DATA_BITS-1:0];
      tx_pps           <= !measured ? '0 : (|quo_tx[DW-1:DATA_BITS]) ? '1
                                           : quo_tx[DATA_BITS-1:0];
      rx_pps           <= !measured ? '0 : (|quo_rx[DW-1:DATA_BITS]) ? '1
                                           : quo_rx[DATA_BITS-1:0];
      rx_rate_mbps     <= !measured ? '0 : (|quo_rxb[DW-1:DATA_BITS]) ? '1
                                           : quo_rxb[DATA_BITS-1:0];
      tx_rate_mbps     <= !measured ? '0 : (|quo_txb[DW-1:DATA_BITS]) ? '1
                                           : quo_txb[DATA_BITS-1:0];
      rx_busy          <= measured ? busy_new : busy_flag;
      cpu_mode         <= changed ? req : mode;
      cpu_mode_changed <= changed;
      window_closed    <= measured && info.closed;
    end
  end

endmodule

// ----- hdl/link_throughput_monitor.sv -----
// Top level of the link throughput monitor: configuration registers and the front/queue/back split.
//
// The monitor sums receive and transmit packet and byte counts from add beats and, on each
// tick beat, measures the time since the window start and reports packets per second and
// approximate Mbps, a receive-busy flag and a busy/idle CPU mode request with hysteresis.
// Add beats are accepted every cycle while in_stall is low. On a tick beat the front end
// classifies it (too short, stale restart, or measured), updates the counters and the window,
// and pushes a snapshot into a two-entry queue. The back end then works on one tick at a time:
// a short or stale tick goes from the idle state straight to the finish state, while a measured
// tick first passes through the divide state, where five restoring divider lanes sharing the
// elapsed time as divisor produce one quotient bit per cycle. The dividend is COUNTER_BITS + 10
// bits wide, or 33 when that is not above 32. in_stall rises only while both queue entries
// hold ticks, which also holds back add beats. Results leave through an output register, so
// a result waiting on out_stall does not keep the back end from starting its next division.
// Configuration registers are written through cfg_write/cfg_index/cfg_data; the user must
// write them only while the block is idle, which the block itself does not enforce.
// cfg_data is 16 bits wide and narrower registers take its low bits.
module link_throughput_monitor import ltm_pkg::*; #(
  parameter int COUNTER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [15:0] amount,
  input  logic [31:0] now_ms,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  outcome,
  output logic [31:0] total_pps,
  output logic [31:0] tx_pps,
  output logic [31:0] rx_pps,
  output logic [31:0] rx_rate_mbps,
  output logic [31:0] tx_rate_mbps,
  output logic        rx_busy,
  output logic [1:0]  cpu_mode,
  output logic        cpu_mode_changed,
  output logic        window_closed
);

  // One queue entry is the tick classification plus five counter snapshots.
  localparam int EW = $bits(ltm_tick_t) + 5 * COUNTER_BITS;

  ltm_cfg_t      cfg;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  logic [EW-1:0] q_in;
  logic [EW-1:0] q_head;

  // Configuration registers; each write takes the low bits of cfg_data that the register needs.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      case (ltm_reg_t'(cfg_index))
        REG_PERIOD:   cfg.period   <= cfg_data;
        REG_WINDOW:   cfg.window   <= cfg_data[7:0];
        REG_LOAD_LOW: cfg.load_low <= cfg_data;
        REG_BIND:     cfg.bind_en  <= cfg_data[0];
        REG_TX_HIGH:  cfg.tx_high  <= cfg_data;
        REG_TX_LOW:   cfg.tx_low   <= cfg_data;
        REG_RX_HIGH:  cfg.rx_high  <= cfg_data;
        REG_RX_LOW:   cfg.rx_low   <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front owns the counters, the tick count and the window start.
  ltm_front #(.COUNTER_BITS(COUNTER_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .amount   (amount),
    .now_ms   (now_ms),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  ltm_queue #(.W(EW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // The back owns the busy flag and the CPU mode, updated in tick order.
  ltm_back #(.COUNTER_BITS(COUNTER_BITS)) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .q_data           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .outcome          (outcome),
    .total_pps        (total_pps),
    .tx_pps           (tx_pps),
    .rx_pps           (rx_pps),
    .rx_rate_mbps     (rx_rate_mbps),
    .tx_rate_mbps     (tx_rate_mbps),
    .rx_busy          (rx_busy),
    .cpu_mode         (cpu_mode),
    .cpu_mode_changed (cpu_mode_changed),
    .window_closed    (window_closed)
  );

`ifndef SYNTHESIS
  // A tick is never pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("tick pushed into a full queue");

  // Short and stale results carry no rates, no mode change and no window close.
  a_quiet_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome != OUT_MEASURED)) |->
      (!cpu_mode_changed && !window_closed && (total_pps == '0) && (rx_rate_mbps == '0)))
    else $error("unmeasured result carries measurement fields");

  // A reported mode change always lands on a real request.
  a_mode_change: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cpu_mode_changed) |-> ((cpu_mode == MODE_BUSY) || (cpu_mode == MODE_IDLE)))
    else $error("mode change reported without a busy or idle request");
`endif

endmodule
